### design/cmf_pkg.sv
package cmf_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_WIDTH = 1024;
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = 16;
  localparam int CFG_WIDTH_BITS = 11;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int MIN_DIM = 3;
  localparam int RESET_WIDTH = 1024;
  localparam int RESET_HEIGHT = 1024;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COL_BITS-1:0] col_t;
  typedef logic [ROW_BITS-1:0] row_t;

  typedef struct packed {
    sample_t above;
    sample_t two_above;
  } line_entry_t;

  typedef struct packed {
    sample_t filtered;
    row_t    row;
    col_t    col;
    logic    last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

### design/cmf_in_if.sv
interface cmf_in_if;
  logic             valid;
  logic             ready;
  cmf_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### design/cmf_out_if.sv
interface cmf_out_if;
  logic             valid;
  logic             ready;
  cmf_pkg::sample_t filtered;
  cmf_pkg::row_t    out_row;
  cmf_pkg::col_t    out_col;
  logic             frame_last;

  modport source (output valid, output filtered, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input filtered, input out_row, input out_col,
                input frame_last, output ready);
endinterface

### design/cross_median_filter_top.sv
// channel   dir  payload                                    transfer
// samples   in   sample                                     valid & ready
// results   out  filtered, out_row, out_col, frame_last     valid & ready
// cfg       in   cfg_index, cfg_data                        cfg_wen
//
// one sample per cycle while ready is high; last grid row yields two results per sample, so the
// output port (one result per cycle) throttles the input on that row
// from sample transaction to the output queue a sample passes the line memory read,
// then the registered median compare
// rst is synchronous; line memory contents are not cleared and no clearing pass runs
// ready drops when the 8-entry output queue has fewer than two unreserved slots
module cross_median_filter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [cmf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [cmf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  cmf_in_if.sink                                samples,
  cmf_out_if.source                             results
);

  cmf_pkg::col_t last_col;
  cmf_pkg::row_t last_row;
  cmf_pkg::col_t col;
  cmf_pkg::row_t row;
  logic [cmf_pkg::FIFO_CNT_BITS-1:0] reserved;
  logic [cmf_pkg::CFG_WIDTH_BITS-1:0] width_raw;
  logic [cmf_pkg::CFG_WIDTH_BITS-1:0] width_clamped;
  cmf_pkg::row_t height_clamped;
  logic accept;
  logic pop;
  logic has0, two0, border0;
  logic [1:0] nres0;

  // stage 1: memory data arrives
  logic v1, has1, two1, border1, last1;
  cmf_pkg::sample_t s1;
  cmf_pkg::col_t c1;
  cmf_pkg::row_t r1;
  cmf_pkg::sample_t win_left;
  cmf_pkg::line_entry_t rd_a, rd_b;
  cmf_pkg::line_entry_t wdata;

  // stage 2: median final compare
  logic v2, has2, two2, border2, last2;
  cmf_pkg::sample_t s2, centre2;
  cmf_pkg::col_t c2;
  cmf_pkg::row_t r2;
  cmf_pkg::sample_t median;
  cmf_pkg::push_t push;

  assign accept = samples.valid & samples.ready;
  assign samples.ready = (reserved <=
                          cmf_pkg::FIFO_CNT_BITS'(cmf_pkg::FIFO_DEPTH - 2));

  assign width_raw = cfg_data[cmf_pkg::CFG_WIDTH_BITS-1:0];
  always_comb begin
    if (width_raw < cmf_pkg::CFG_WIDTH_BITS'(cmf_pkg::MIN_DIM)) begin
      width_clamped = cmf_pkg::CFG_WIDTH_BITS'(cmf_pkg::MIN_DIM);
    end else if (width_raw > cmf_pkg::CFG_WIDTH_BITS'(cmf_pkg::MAX_WIDTH)) begin
      width_clamped = cmf_pkg::CFG_WIDTH_BITS'(cmf_pkg::MAX_WIDTH);
    end else begin
      width_clamped = width_raw;
    end
    if (cfg_data < cmf_pkg::CFG_DATA_BITS'(cmf_pkg::MIN_DIM)) begin
      height_clamped = cmf_pkg::ROW_BITS'(cmf_pkg::MIN_DIM);
    end else begin
      height_clamped = cfg_data;
    end
  end

  assign has0 = (row != '0);
  assign two0 = (row == last_row);
  assign border0 = (row == cmf_pkg::ROW_BITS'(1)) || (col == '0) || (col == last_col);
  assign nres0 = {1'b0, has0} + {1'b0, two0};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= cmf_pkg::COL_BITS'(cmf_pkg::RESET_WIDTH - 1);
      last_row <= cmf_pkg::ROW_BITS'(cmf_pkg::RESET_HEIGHT - 1);
      col <= '0;
      row <= '0;
      reserved <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      reserved <= reserved + cmf_pkg::FIFO_CNT_BITS'(accept ? nres0 : 2'd0)
                  - cmf_pkg::FIFO_CNT_BITS'(pop);
      if (cfg_wen) begin
        case (cfg_index)
          cmf_pkg::REG_GRID_WIDTH: begin
            last_col <= cmf_pkg::COL_BITS'(width_clamped - 1'b1);
            col <= '0;
            row <= '0;
          end
          cmf_pkg::REG_GRID_HEIGHT: begin
            last_row <= height_clamped - 1'b1;
            col <= '0;
            row <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        if (col == last_col) begin
          col <= '0;
          row <= (row == last_row) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1 <= samples.sample;
    c1 <= col;
    r1 <= row;
    has1 <= has0;
    two1 <= two0;
    border1 <= border0;
    last1 <= (col == last_col);
    if (v1) begin
      win_left <= rd_a.above;
    end
    s2 <= s1;
    c2 <= c1;
    r2 <= r1;
    has2 <= has1;
    two2 <= two1;
    border2 <= border1;
    last2 <= last1;
    centre2 <= rd_a.above;
  end

  assign wdata.above = s1;
  assign wdata.two_above = rd_a.above;

  cmf_line_ram u_line_ram (
    .clk     (clk),
    .we      (v1),
    .waddr   (c1),
    .wdata   (wdata),
    .raddr_a (col),
    .raddr_b (col + 1'b1),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  cmf_median5 u_median5 (
    .clk    (clk),
    .a      (rd_a.above),
    .b      (s1),
    .c      (rd_a.two_above),
    .d      (win_left),
    .e      (rd_b.above),
    .median (median)
  );

  always_comb begin
    push.n = v2 ? ({1'b0, has2} + {1'b0, two2}) : 2'd0;
    push.first.filtered = border2 ? centre2 : median;
    push.first.row = r2 - 1'b1;
    push.first.col = c2;
    push.first.last = 1'b0;
    push.second.filtered = s2;
    push.second.row = r2;
    push.second.col = c2;
    push.second.last = last2;
  end

  cmf_result_fifo u_result_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (pop),
    .results (results)
  );

endmodule

### design/cmf_line_ram.sv
module cmf_line_ram (
  input  logic                  clk,
  input  logic                  we,
  input  cmf_pkg::col_t         waddr,
  input  cmf_pkg::line_entry_t  wdata,
  input  cmf_pkg::col_t         raddr_a,
  input  cmf_pkg::col_t         raddr_b,
  output cmf_pkg::line_entry_t  rdata_a,
  output cmf_pkg::line_entry_t  rdata_b
);

  cmf_pkg::line_entry_t mem [cmf_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### design/cmf_median5.sv
module cmf_median5 (
  input  logic             clk,
  input  cmf_pkg::sample_t a,
  input  cmf_pkg::sample_t b,
  input  cmf_pkg::sample_t c,
  input  cmf_pkg::sample_t d,
  input  cmf_pkg::sample_t e,
  output cmf_pkg::sample_t median
);

  cmf_pkg::sample_t lo0, hi0, lo1, hi1;
  cmf_pkg::sample_t p_next, q_next, u_next;
  cmf_pkg::sample_t p, q, u, e2;
  cmf_pkg::sample_t lo, hi;
  logic ue, pu, pe, qu, qe;
  logic p_lt_lo, q_lt_lo, p_lt_hi;

  // first stage: sort two pairs, drop the smaller of the two minima
  always_comb begin
    lo0 = (a < b) ? a : b;
    hi0 = (a < b) ? b : a;
    lo1 = (c < d) ? c : d;
    hi1 = (c < d) ? d : c;
    if (lo0 < lo1) begin
      p_next = lo1;
      q_next = hi1;
      u_next = hi0;
    end else begin
      p_next = lo0;
      q_next = hi0;
      u_next = hi1;
    end
  end

  always_ff @(posedge clk) begin
    p  <= p_next;
    q  <= q_next;
    u  <= u_next;
    e2 <= e;
  end

  // second stage: second smallest of p <= q, u, e2
  always_comb begin
    ue = u < e2;
    pu = p < u;
    pe = p < e2;
    qu = q < u;
    qe = q < e2;
    lo = ue ? u : e2;
    hi = ue ? e2 : u;
    p_lt_lo = ue ? pu : pe;
    q_lt_lo = ue ? qu : qe;
    p_lt_hi = ue ? pe : pu;
    if (p_lt_lo) begin
      median = q_lt_lo ? q : lo;
    end else begin
      median = p_lt_hi ? p : hi;
    end
  end

endmodule

### design/cmf_result_fifo.sv
module cmf_result_fifo (
  input  logic           clk,
  input  logic           rst,
  input  cmf_pkg::push_t push,
  output logic           pop,
  cmf_out_if.source      results
);

  cmf_pkg::out_item_t mem [cmf_pkg::FIFO_DEPTH];
  logic [cmf_pkg::FIFO_PTR_BITS-1:0] wr_ptr;
  logic [cmf_pkg::FIFO_PTR_BITS-1:0] rd_ptr;
  logic [cmf_pkg::FIFO_CNT_BITS-1:0] count;
  logic [cmf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_1;
  cmf_pkg::out_item_t head;

  assign wr_ptr_1 = wr_ptr + 1'b1;
  assign head = mem[rd_ptr];
  assign results.valid = (count != '0);
  assign results.filtered = head.filtered;
  assign results.out_row = head.row;
  assign results.out_col = head.col;
  assign results.frame_last = head.last;
  assign pop = results.valid & results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + cmf_pkg::FIFO_PTR_BITS'(push.n);
      rd_ptr <= rd_ptr + cmf_pkg::FIFO_PTR_BITS'(pop);
      count <= count + cmf_pkg::FIFO_CNT_BITS'(push.n) - cmf_pkg::FIFO_CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

endmodule

### bench/cross_median_filter_top_test.sv
module cross_median_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cmf_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int SHOWN_FAILURES = 10;
  localparam int SMALL_ITEMS = 1025;
  localparam sample_t S_MAX = 32'sh7fffffff;
  localparam sample_t S_MIN = 32'sh80000000;

  typedef struct {
    bit                        is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    sample_t                   smp;
    bit                        typed;
    out_item_t                 want;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wen;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  cmf_in_if  samples_if ();
  cmf_out_if results_if ();

  cross_median_filter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  always #2 clk = ~clk;

  // filter state as the block should hold it
  logic [CFG_WIDTH_BITS-1:0] grid_w;
  logic [CFG_DATA_BITS-1:0]  grid_h;
  sample_t                   row_above[MAX_WIDTH];
  sample_t                   row_two_above[MAX_WIDTH];
  sample_t                   win[3];
  int                        row_pos;
  int                        col_pos;

  out_item_t due_results[$];
  dir_row_t  dir_rows[$];

  int      failures;
  int      samples_sent;
  int      results_checked;
  int      frames_seen;
  int      reg_writes;
  bit      src_valid;
  bit      cfg_active;
  bit      src_burst;
  bit      sink_burst;
  sample_t last_sample;

  initial begin
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    results_if.ready = 1'b0;
  end

  function automatic int eff_w();
    int w;
    w = int'(grid_w);
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = int'(grid_h);
    if (h < MIN_DIM) h = MIN_DIM;
    return h;
  endfunction

  function automatic out_item_t mk_result(sample_t f, int r, int c, bit l);
    out_item_t o;
    o.filtered = f;
    o.row = row_t'(r);
    o.col = col_t'(c);
    o.last = l;
    return o;
  endfunction

  function automatic sample_t median_of_five(sample_t a, sample_t b, sample_t c,
                                             sample_t d, sample_t e);
    sample_t v[5];
    sample_t t;
    int i;
    int j;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    v[4] = e;
    for (i = 1; i < 5; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] < t) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = t;
    end
    return v[2];
  endfunction

  // advance the filter by one sample and queue what it emits
  task automatic filter_sample(input sample_t s, input bit typed, input out_item_t want);
    int w;
    int h;
    int r;
    int c;
    sample_t val;
    w = eff_w();
    h = eff_h();
    r = row_pos;
    c = col_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    win[0] = win[1];
    win[1] = (c == 0) ? row_above[0] : win[2];
    win[2] = (c + 1 < w) ? row_above[c + 1] : '0;
    if (r >= 1 || typed) begin
      if (r - 1 == 0 || c == 0 || c == w - 1) begin
        val = win[1];
      end else begin
        val = median_of_five(win[1], s, row_two_above[c], win[0], win[2]);
      end
      due_results.push_back(typed ? want : mk_result(val, r - 1, c, 1'b0));
      if (r == h - 1) begin
        due_results.push_back(mk_result(s, r, c, c == w - 1));
      end
    end
    row_two_above[c] = row_above[c];
    row_above[c] = s;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= SHOWN_FAILURES) $display("ERROR: %s", msg);
  endtask

  task automatic go_idle();
    if (src_valid) begin
      samples_if.valid <= 1'b0;
      src_valid = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    if (!cfg_active) begin
      go_idle();
      wait_drained();
    end
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_active = 1'b1;
    reg_writes++;
    case (idx)
      REG_GRID_WIDTH: begin
        grid_w = data[CFG_WIDTH_BITS-1:0];
        row_pos = 0;
        col_pos = 0;
      end
      REG_GRID_HEIGHT: begin
        grid_h = data;
        row_pos = 0;
        col_pos = 0;
      end
      default: ;
    endcase
  endtask

  task automatic end_writes();
    if (cfg_active) begin
      cfg_wen <= 1'b0;
      cfg_active = 1'b0;
    end
  endtask

  task automatic push_sample(input sample_t v, input bit typed, input out_item_t want);
    int gap;
    bit hs;
    end_writes();
    gap = src_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      go_idle();
      repeat (gap) @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.sample <= v;
    src_valid = 1'b1;
    do begin
      @(negedge clk);
      hs = samples_if.ready;
      @(posedge clk);
    end while (!hs);
    samples_sent++;
    filter_sample(v, typed, want);
  endtask

  function automatic sample_t rand_sample();
    sample_t v;
    case ($urandom_range(0, 9))
      0: v = S_MAX;
      1: v = S_MIN;
      2: v = last_sample;
      3, 4: v = sample_t'(int'($urandom_range(0, 6)) - 3);
      default: v = sample_t'($urandom);
    endcase
    last_sample = v;
    return v;
  endfunction

  task automatic table_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    dir_row_t d;
    d.is_cfg = 1'b1;
    d.idx = idx;
    d.data = data;
    d.smp = '0;
    d.typed = 1'b0;
    d.want = '0;
    dir_rows.push_back(d);
  endtask

  task automatic table_sample(input sample_t s, input bit typed, input out_item_t want);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.idx = '0;
    d.data = '0;
    d.smp = s;
    d.typed = typed;
    d.want = want;
    dir_rows.push_back(d);
  endtask

  initial begin : result_sink
    int stall;
    bit hs;
    bit snk_ready;
    out_item_t got;
    out_item_t want;
    snk_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
      if (stall > 0) begin
        if (snk_ready) begin
          results_if.ready <= 1'b0;
          snk_ready = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      if (!snk_ready) begin
        results_if.ready <= 1'b1;
        snk_ready = 1'b1;
      end
      do begin
        @(negedge clk);
        hs = results_if.valid;
        got.filtered = results_if.filtered;
        got.row = results_if.out_row;
        got.col = results_if.out_col;
        got.last = results_if.frame_last;
        @(posedge clk);
      end while (hs !== 1'b1);
      if (got.last === 1'b1) frames_seen++;
      if (due_results.size() == 0) begin
        note_failure($sformatf("unexpected result filtered=%h row=%0d col=%0d last=%b",
                               got.filtered, got.row, got.col, got.last));
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (got.filtered !== want.filtered || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
          note_failure($sformatf(
            "result mismatch exp filtered=%h row=%0d col=%0d last=%b, got %h %0d %0d %b",
            want.filtered, want.row, want.col, want.last,
            got.filtered, got.row, got.col, got.last));
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    int we;
    int he;
    int small_items;
    logic [CFG_DATA_BITS-1:0] wv;
    logic [CFG_DATA_BITS-1:0] hv;

    grid_w = CFG_WIDTH_BITS'(RESET_WIDTH);
    grid_h = CFG_DATA_BITS'(RESET_HEIGHT);
    for (n = 0; n < MAX_WIDTH; n++) begin
      row_above[n] = '0;
      row_two_above[n] = '0;
    end
    win[0] = '0;
    win[1] = '0;
    win[2] = '0;
    row_pos = 0;
    col_pos = 0;

    // reset geometry, first row only
    table_sample(S_MAX, 1'b0, '0);
    table_sample(S_MIN, 1'b0, '0);
    // smallest grid, extremes of the sample range
    table_cfg(REG_GRID_WIDTH, 16'd3);
    table_cfg(REG_GRID_HEIGHT, 16'd3);
    table_sample(S_MAX, 1'b0, '0);
    table_sample(S_MIN, 1'b0, '0);
    table_sample(32'sd0, 1'b0, '0);
    table_sample(32'sd5, 1'b1, mk_result(S_MAX, 0, 0, 1'b0));
    table_sample(-32'sd1, 1'b1, mk_result(S_MIN, 0, 1, 1'b0));
    table_sample(32'sd7, 1'b1, mk_result(32'sd0, 0, 2, 1'b0));
    table_sample(32'sd1, 1'b1, mk_result(32'sd5, 1, 0, 1'b0));
    table_sample(32'sd2, 1'b0, '0);
    table_sample(32'sd3, 1'b1, mk_result(32'sd7, 1, 2, 1'b0));
    // clamped geometry, ties around the center
    table_cfg(REG_GRID_WIDTH, 16'd0);
    table_cfg(REG_GRID_HEIGHT, 16'd2);
    table_sample(32'sd4, 1'b0, '0);
    table_sample(32'sd4, 1'b0, '0);
    table_sample(32'sd4, 1'b0, '0);
    table_sample(32'sd4, 1'b1, mk_result(32'sd4, 0, 0, 1'b0));
    table_sample(S_MIN, 1'b1, mk_result(32'sd4, 0, 1, 1'b0));
    table_sample(32'sd4, 1'b1, mk_result(32'sd4, 0, 2, 1'b0));
    table_sample(S_MAX, 1'b1, mk_result(32'sd4, 1, 0, 1'b0));
    table_sample(32'sd4, 1'b0, '0);
    table_sample(S_MAX, 1'b1, mk_result(32'sd4, 1, 2, 1'b0));
    // frame cut short by a register write
    table_cfg(REG_GRID_WIDTH, 16'd4);
    table_cfg(REG_GRID_HEIGHT, 16'd4);
    table_sample(-32'sd8, 1'b0, '0);
    table_sample(32'sd8, 1'b0, '0);
    table_sample(32'sh12345678, 1'b0, '0);
    table_sample(32'shedcba987, 1'b0, '0);
    table_sample(32'sd1, 1'b1, mk_result(-32'sd8, 0, 0, 1'b0));
    table_cfg(REG_GRID_HEIGHT, 16'd3);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    small_items = 0;
    while (small_items < SMALL_ITEMS) begin
      src_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 7))
          0: wv = CFG_DATA_BITS'($urandom_range(0, 2));
          1: wv = 16'd3;
          6: wv = CFG_DATA_BITS'($urandom_range(17, 64));
          default: wv = CFG_DATA_BITS'($urandom_range(4, 16));
        endcase
        case ($urandom_range(0, 7))
          0: hv = CFG_DATA_BITS'($urandom_range(0, 2));
          1: hv = 16'd3;
          6: hv = 16'hffff;
          7: hv = CFG_DATA_BITS'($urandom_range(11, 20));
          default: hv = CFG_DATA_BITS'($urandom_range(4, 10));
        endcase
        if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_WIDTH, wv);
        if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_HEIGHT, hv);
      end
      we = eff_w();
      he = eff_h();
      if (he > 20 || we * he > 300) begin
        n = we * $urandom_range(3, 6) + $urandom_range(0, we - 1);
      end else begin
        n = we * he * $urandom_range(1, 3);
      end
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > SMALL_ITEMS - small_items) n = SMALL_ITEMS - small_items;
      repeat (n) begin
        if ($urandom_range(0, 99) == 0 && due_results.size() != 0) begin
          go_idle();
          while (due_results.size() != 0) @(posedge clk);
        end
        push_sample(rand_sample(), 1'b0, '0);
        small_items++;
      end
    end

    end_writes();
    go_idle();
    wait_drained();
    if (due_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never came out", due_results.size()));
    end
    $display("covered %0d samples across %0d register writes, grids from 3x3 to width 64",
             samples_sent, reg_writes);
    $display("checked %0d results, %0d complete frames, %0d failures",
             results_checked, frames_seen, failures);
    if (failures == 0) begin
      $display("PASS cross_median_filter_top");
    end else begin
      $display("FAIL cross_median_filter_top");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("timeout with %0d results still expected", due_results.size());
    $display("FAIL cross_median_filter_top");
    $finish;
  end

endmodule
